// ===== rtl/ijs_pkg.sv =====
// ----------------------------------------------------------------------------
// ijs_pkg
// shared constants, types and helpers for the interval jitter statistics block
// ----------------------------------------------------------------------------
package ijs_pkg;

    localparam int DEF_INTERVAL_BITS = 32;
    localparam int DEF_COUNT_BITS    = 32;
    localparam int TS_BITS           = 63;
    localparam int SUM_BITS          = 64;
    localparam int FIELD_BITS        = 32;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_UPDATE,
        BK_DIV_I_GO,
        BK_DIV_I_WAIT,
        BK_DIV_J_GO,
        BK_DIV_J_WAIT,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic                  measured;
        logic [FIELD_BITS-1:0] interval_us;
        logic [FIELD_BITS-1:0] sample_count;
        logic [FIELD_BITS-1:0] interval_min;
        logic [FIELD_BITS-1:0] interval_max;
        logic [FIELD_BITS-1:0] interval_mean;
        logic [SUM_BITS-1:0]   interval_square_sum;
        logic [FIELD_BITS-1:0] jitter_us;
        logic [FIELD_BITS-1:0] jitter_mean;
        logic [FIELD_BITS-1:0] jitter_lo;
        logic [FIELD_BITS-1:0] jitter_hi;
    } t_result;

    // clamp a wide value to the 32-bit field range
    function automatic logic [FIELD_BITS-1:0] sat32(input logic [SUM_BITS-1:0] v);
        return (v[SUM_BITS-1:FIELD_BITS] != '0) ? '1 : v[FIELD_BITS-1:0];
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add64(input logic [SUM_BITS-1:0] a,
                                                      input logic [SUM_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

endpackage

// ===== rtl/ijs_front.sv =====
// ----------------------------------------------------------------------------
// ijs_front
// accepts words, keeps the baseline and classifies each word for the back end
// ----------------------------------------------------------------------------
module ijs_front import ijs_pkg::*; #(
    parameter int INTERVAL_BITS = DEF_INTERVAL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_enable,
    input  logic                     i_valid,
    input  logic                     i_action,
    input  logic [TS_BITS-1:0]       i_timestamp_us,
    input  logic                     i_full,
    output logic                     o_stall,
    output logic                     o_push,
    output logic                     o_measure,
    output logic [INTERVAL_BITS-1:0] o_interval
);

    logic [TS_BITS-1:0] r_base_time, n_base_time;
    logic               r_base_valid, n_base_valid;
    logic [TS_BITS-1:0] diff;
    logic               accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // difference wraps modulo 2^63, then clamps
    assign diff       = i_timestamp_us - r_base_time;
    assign o_interval = (diff[TS_BITS-1:INTERVAL_BITS] != '0) ? '1
                                                              : diff[INTERVAL_BITS-1:0];
    assign o_measure  = i_enable && i_action && r_base_valid;

    always_comb begin
        n_base_time  = r_base_time;
        n_base_valid = r_base_valid;
        if (accept && i_enable) begin
            n_base_time  = i_timestamp_us;
            n_base_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_time  <= '0;
            r_base_valid <= 1'b0;
        end else begin
            r_base_time  <= n_base_time;
            r_base_valid <= n_base_valid;
        end
    end

endmodule

// ===== rtl/ijs_fifo.sv =====
// ----------------------------------------------------------------------------
// ijs_fifo
// small register queue between the front and back ends
// ----------------------------------------------------------------------------
module ijs_fifo import ijs_pkg::*; #(
    parameter int WIDTH = DEF_INTERVAL_BITS + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/ijs_div.sv =====
// ----------------------------------------------------------------------------
// ijs_div
// iterative restoring divider, 64-bit dividend, two quotient bits per cycle
// ----------------------------------------------------------------------------
module ijs_div import ijs_pkg::*; #(
    parameter int DIVISOR_BITS = DEF_COUNT_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SUM_BITS-1:0]     i_dividend,
    input  logic [DIVISOR_BITS-1:0] i_divisor,
    output logic                    o_done,
    output logic [SUM_BITS-1:0]     o_quotient
);

    localparam int DW    = DIVISOR_BITS;
    localparam int STEPS = SUM_BITS / 2;
    localparam int SW    = $clog2(STEPS);

    logic [SUM_BITS-1:0] r_work, n_work;
    logic [DW-1:0]       r_rem, n_rem;
    logic [DW-1:0]       r_dvs;
    logic [SW-1:0]       r_step, n_step;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DW:0]         sh0, sh1;
    logic [DW-1:0]       rem0, rem1;
    logic                q0, q1;

    assign o_done     = r_done;
    assign o_quotient = r_work;

    always_comb begin
        sh0  = {r_rem, r_work[SUM_BITS-1]};
        q0   = (sh0 >= {1'b0, r_dvs});
        rem0 = q0 ? DW'(sh0 - {1'b0, r_dvs}) : sh0[DW-1:0];
        sh1  = {rem0, r_work[SUM_BITS-2]};
        q1   = (sh1 >= {1'b0, r_dvs});
        rem1 = q1 ? DW'(sh1 - {1'b0, r_dvs}) : sh1[DW-1:0];

        n_work = r_work;
        n_rem  = r_rem;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start && !r_busy) begin
            n_work = i_dividend;
            n_rem  = '0;
            n_step = SW'(STEPS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_work = {r_work[SUM_BITS-3:0], q0, q1};
            n_rem  = rem1;
            n_step = r_step - SW'(1);
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        if (i_start && !r_busy) begin
            r_dvs <= i_divisor;
        end
    end

endmodule

// ===== rtl/ijs_back.sv =====
// ----------------------------------------------------------------------------
// ijs_back
// updates the running statistics and forms the result word
// ----------------------------------------------------------------------------
module ijs_back import ijs_pkg::*; #(
    parameter int INTERVAL_BITS = DEF_INTERVAL_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  logic                     i_measure,
    input  logic [INTERVAL_BITS-1:0] i_interval,
    output logic                     o_pop,
    input  logic                     i_stall,
    output logic                     o_valid,
    output t_result                  o_result
);

    localparam int IW = INTERVAL_BITS;
    localparam int CB = COUNT_BITS;

    t_back_state r_state, n_state;

    logic                r_meas;
    logic [IW-1:0]       r_iv;
    logic [SUM_BITS-1:0] r_sq;
    logic [SUM_BITS-1:0] iv_ext;

    logic [CB-1:0]       r_count;
    logic [SUM_BITS-1:0] r_isum, r_ssum, r_jtot;
    logic [IW-1:0]       r_imin, r_imax, r_prev;
    logic [IW-1:0]       r_jmin, r_jmax, r_jlast;
    logic [IW-1:0]       jit;

    logic [SUM_BITS-1:0] r_qi, r_qj;
    logic                r_out_valid;
    t_result             r_res, res;

    logic                div_start, div_done;
    logic [SUM_BITS-1:0] div_dividend, div_quotient;
    logic [CB-1:0]       div_divisor;
    logic                load;

    ijs_div #(
        .DIVISOR_BITS (CB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign iv_ext = SUM_BITS'(r_iv);
    assign jit    = (r_iv > r_prev) ? r_iv - r_prev : r_prev - r_iv;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:       if (!i_empty) n_state = BK_SQUARE;
            BK_SQUARE:     n_state = BK_UPDATE;
            BK_UPDATE:     n_state = BK_DIV_I_GO;
            BK_DIV_I_GO:   n_state = BK_DIV_I_WAIT;
            BK_DIV_I_WAIT: if (div_done) n_state = BK_DIV_J_GO;
            BK_DIV_J_GO:   n_state = BK_DIV_J_WAIT;
            BK_DIV_J_WAIT: if (div_done) n_state = BK_OUT;
            BK_OUT:        if (!r_out_valid || !i_stall) n_state = BK_IDLE;
            default:       n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_isum;
        div_divisor  = r_count;
        load         = 1'b0;
        case (r_state)
            BK_IDLE:     o_pop = !i_empty;
            BK_DIV_I_GO: div_start = 1'b1;
            BK_DIV_J_GO: begin
                div_start    = 1'b1;
                div_dividend = r_jtot;
                div_divisor  = r_count - CB'(1);
            end
            BK_OUT:      load = !r_out_valid || !i_stall;
            default:     ;
        endcase
    end

    always_comb begin
        res.measured            = r_meas;
        res.interval_us         = sat32(SUM_BITS'(r_prev));
        res.sample_count        = sat32(SUM_BITS'(r_count));
        res.interval_min        = sat32(SUM_BITS'(r_imin));
        res.interval_max        = sat32(SUM_BITS'(r_imax));
        res.interval_mean       = (r_count != '0) ? sat32(r_qi) : '0;
        res.interval_square_sum = r_ssum;
        res.jitter_us           = sat32(SUM_BITS'(r_jlast));
        res.jitter_mean         = (r_count > CB'(1)) ? sat32(r_qj) : '0;
        res.jitter_lo           = sat32(SUM_BITS'(r_jmin));
        res.jitter_hi           = sat32(SUM_BITS'(r_jmax));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_isum      <= '0;
            r_ssum      <= '0;
            r_jtot      <= '0;
            r_imin      <= '0;
            r_imax      <= '0;
            r_prev      <= '0;
            r_jmin      <= '0;
            r_jmax      <= '0;
            r_jlast     <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_UPDATE && r_meas) begin
                if (r_count != '1) begin
                    r_count <= r_count + CB'(1);
                end
                r_isum <= sat_add64(r_isum, iv_ext);
                r_ssum <= sat_add64(r_ssum, r_sq);
                if (r_count == '0) begin
                    r_imin <= r_iv;
                    r_imax <= r_iv;
                end else begin
                    if (r_iv > r_imax) r_imax <= r_iv;
                    if (r_iv < r_imin) r_imin <= r_iv;
                    r_jlast <= jit;
                    if (r_count == CB'(1)) begin
                        r_jtot <= SUM_BITS'(jit);
                        r_jmin <= jit;
                        r_jmax <= jit;
                    end else begin
                        r_jtot <= sat_add64(r_jtot, SUM_BITS'(jit));
                        if (jit > r_jmax) r_jmax <= jit;
                        if (jit < r_jmin) r_jmin <= jit;
                    end
                end
                r_prev <= r_iv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_meas <= i_measure;
            r_iv   <= i_interval;
        end
        // squares beyond 32-bit intervals clamp
        if (r_state == BK_SQUARE) begin
            r_sq <= (iv_ext[SUM_BITS-1:FIELD_BITS] != '0) ? '1
                    : iv_ext[FIELD_BITS-1:0] * iv_ext[FIELD_BITS-1:0];
        end
        if (r_state == BK_DIV_I_WAIT && div_done) begin
            r_qi <= div_quotient;
        end
        if (r_state == BK_DIV_J_WAIT && div_done) begin
            r_qj <= div_quotient;
        end
        if (load) begin
            r_res <= res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/interval_jitter_statistics.sv =====
// ----------------------------------------------------------------------------
// interval_jitter_statistics
// running interval and jitter statistics over microsecond timestamps
// ----------------------------------------------------------------------------
// each accepted word gives exactly one result word. a restart word (action 0),
// or a measure word with no baseline yet, only loads the baseline; a measure
// word takes the interval since the baseline and clamps it, its timestamp
// becomes the new baseline, and the back end updates count, sums, extremes
// and jitter. the shared divider in the back end yields two quotient bits
// per cycle and runs twice per word (interval mean, then jitter mean), after
// square and update and before output load. the front end keeps the
// baseline and, while the queue has room, classifies words at full clock
// rate into a two-word queue, so up to two further words are taken while
// the back end works, and a finished result waits in the output register
// without holding up the queue. enable resets high; with it low words still
// return a result (measured low) but change nothing. the configuration port
// is always ready and should only be written while the block is idle
// ----------------------------------------------------------------------------
module interval_jitter_statistics import ijs_pkg::*; #(
    parameter int INTERVAL_BITS = DEF_INTERVAL_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data,
    // input word channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [TS_BITS-1:0]    i_timestamp_us,
    // result word channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_measured,
    output logic [FIELD_BITS-1:0] o_interval_us,
    output logic [FIELD_BITS-1:0] o_sample_count,
    output logic [FIELD_BITS-1:0] o_interval_min,
    output logic [FIELD_BITS-1:0] o_interval_max,
    output logic [FIELD_BITS-1:0] o_interval_mean,
    output logic [SUM_BITS-1:0]   o_interval_square_sum,
    output logic [FIELD_BITS-1:0] o_jitter_us,
    output logic [FIELD_BITS-1:0] o_jitter_mean,
    output logic [FIELD_BITS-1:0] o_jitter_lo,
    output logic [FIELD_BITS-1:0] o_jitter_hi
);

    localparam int QW = INTERVAL_BITS + 1;

    // enable register, written through the configuration channel
    logic r_enable;

    // front end to queue
    logic                     push, full, measure;
    logic [INTERVAL_BITS-1:0] interval;

    // queue to back end
    logic          pop, empty;
    logic [QW-1:0] q_word;

    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_data;
        end
    end

    // front end: baseline tracking and word classification
    ijs_front #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (r_enable),
        .i_valid        (i_valid),
        .i_action       (i_action),
        .i_timestamp_us (i_timestamp_us),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_measure      (measure),
        .o_interval     (interval)
    );

    // queue word: measure flag above the clamped interval
    ijs_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({measure, interval}),
        .i_pop   (pop),
        .o_data  (q_word),
        .o_empty (empty),
        .o_full  (full)
    );

    // back end: statistics update, means and output register
    ijs_back #(
        .INTERVAL_BITS (INTERVAL_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_measure  (q_word[QW-1]),
        .i_interval (q_word[INTERVAL_BITS-1:0]),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (result)
    );

    assign o_measured            = result.measured;
    assign o_interval_us         = result.interval_us;
    assign o_sample_count        = result.sample_count;
    assign o_interval_min        = result.interval_min;
    assign o_interval_max        = result.interval_max;
    assign o_interval_mean       = result.interval_mean;
    assign o_interval_square_sum = result.interval_square_sum;
    assign o_jitter_us           = result.jitter_us;
    assign o_jitter_mean         = result.jitter_mean;
    assign o_jitter_lo           = result.jitter_lo;
    assign o_jitter_hi           = result.jitter_hi;

endmodule

// ===== rtl/ijs_checker.sv =====
// ----------------------------------------------------------------------------
// ijs_checker
// port level checks on the result channel of the statistics block
// ----------------------------------------------------------------------------
module ijs_checker import ijs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_measured,
    input logic [FIELD_BITS-1:0] o_sample_count,
    input logic [FIELD_BITS-1:0] o_interval_min,
    input logic [FIELD_BITS-1:0] o_interval_max,
    input logic [FIELD_BITS-1:0] o_jitter_mean,
    input logic [SUM_BITS-1:0]   o_interval_square_sum
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_interval_square_sum))
        else $error("stalled result changed");

    // a new sample means at least one interval has been counted
    a_measured_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_measured |-> o_sample_count != '0)
        else $error("sample without count");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sample_count != '0 |-> o_interval_min <= o_interval_max)
        else $error("interval extremes out of order");

    a_jitter_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_sample_count == '0 || o_sample_count == FIELD_BITS'(1))
        |-> o_jitter_mean == '0)
        else $error("jitter mean before second interval");

endmodule

bind interval_jitter_statistics ijs_checker u_ijs_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_valid               (o_valid),
    .i_stall               (i_stall),
    .o_measured            (o_measured),
    .o_sample_count        (o_sample_count),
    .o_interval_min        (o_interval_min),
    .o_interval_max        (o_interval_max),
    .o_jitter_mean         (o_jitter_mean),
    .o_interval_square_sum (o_interval_square_sum)
);

// ===== verif/interval_jitter_statistics_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_jitter_statistics_tb
// self-checking bench for the interval and jitter statistics block
// ----------------------------------------------------------------------------
// a short table of hand-picked words comes first: no baseline yet, zero and
// clamped intervals, timestamps that wrap below the baseline, the square sum
// running into its ceiling, and words sent while the block is disabled. a few
// rows carry their expected statistics typed in; the rest, and all of the
// random traffic that follows, are checked against a local model of the
// running statistics. the random traffic runs in phases with different
// sender gaps, receiver stalls and enable settings, plus one long receiver
// hold-off that backs the block up and one pause that lets it drain
// ----------------------------------------------------------------------------
module interval_jitter_statistics_tb;
    import ijs_pkg::*;

    localparam int          CYCLE_LIMIT   = 800000;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 600;
    localparam logic [63:0] IV_CEIL       = (64'd1 << DEF_INTERVAL_BITS) - 64'd1;
    localparam logic [63:0] COUNT_CEIL    = (64'd1 << DEF_COUNT_BITS) - 64'd1;
    localparam logic        ENABLE_OFF    = 1'b0;
    localparam logic        ENABLE_ON     = 1'b1;

    typedef enum logic {
        ACT_RESTART = 1'b0,
        ACT_MEASURE = 1'b1
    } t_word_action;

    typedef enum logic {
        ROW_WORD,
        ROW_CONFIG
    } t_row_kind;

    typedef struct {
        t_row_kind    kind;
        t_word_action act;
        logic [62:0]  ts;
        logic         cfg_value;
        bit           typed;
        t_result      stats;
    } t_stim_row;

    // ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_action;
    logic [TS_BITS-1:0]    i_timestamp_us;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_measured;
    logic [FIELD_BITS-1:0] o_interval_us;
    logic [FIELD_BITS-1:0] o_sample_count;
    logic [FIELD_BITS-1:0] o_interval_min;
    logic [FIELD_BITS-1:0] o_interval_max;
    logic [FIELD_BITS-1:0] o_interval_mean;
    logic [SUM_BITS-1:0]   o_interval_square_sum;
    logic [FIELD_BITS-1:0] o_jitter_us;
    logic [FIELD_BITS-1:0] o_jitter_mean;
    logic [FIELD_BITS-1:0] o_jitter_lo;
    logic [FIELD_BITS-1:0] o_jitter_hi;

    // traffic shaping, shared between the sender and the receiver
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          hold_request  = 0;
    int          cycle_count   = 0;
    int          mismatch_count = 0;
    logic [62:0] ts_cursor     = '0;

    // expected statistics, oldest first
    t_result     pending_stats[$];
    t_stim_row   stim_rows[$];

    // local copy of the running statistics, reset values
    logic        en_mirror = ENABLE_ON;
    logic [62:0] base_ts   = '0;
    logic        base_ok   = 1'b0;
    logic [63:0] n_samples = '0;
    logic [63:0] iv_total  = '0;
    logic [63:0] sq_total  = '0;
    logic [63:0] iv_lo     = '0;
    logic [63:0] iv_hi     = '0;
    logic [63:0] iv_prev   = '0;
    logic [63:0] jit_total = '0;
    logic [63:0] jit_lo    = '0;
    logic [63:0] jit_hi    = '0;
    logic [63:0] jit_last  = '0;

    interval_jitter_statistics #(
        .INTERVAL_BITS (DEF_INTERVAL_BITS),
        .COUNT_BITS    (DEF_COUNT_BITS)
    ) i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_action              (i_action),
        .i_timestamp_us        (i_timestamp_us),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_measured            (o_measured),
        .o_interval_us         (o_interval_us),
        .o_sample_count        (o_sample_count),
        .o_interval_min        (o_interval_min),
        .o_interval_max        (o_interval_max),
        .o_interval_mean       (o_interval_mean),
        .o_interval_square_sum (o_interval_square_sum),
        .o_jitter_us           (o_jitter_us),
        .o_jitter_mean         (o_jitter_mean),
        .o_jitter_lo           (o_jitter_lo),
        .o_jitter_hi           (o_jitter_hi)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_stats.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // helpers for the statistics model
    // ------------------------------------------------------------------------

    // clamp to the 32-bit output field
    function automatic logic [31:0] to_field(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // 64-bit add that sticks at all ones instead of wrapping
    function automatic logic [63:0] sum_clamped(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic t_result stats_word(
        input logic        measured,
        input logic [31:0] iv,
        input logic [31:0] cnt,
        input logic [31:0] lo,
        input logic [31:0] hi,
        input logic [31:0] mean,
        input logic [63:0] sq,
        input logic [31:0] jit,
        input logic [31:0] jmean,
        input logic [31:0] jlo,
        input logic [31:0] jhi
    );
        t_result r;
        r.measured            = measured;
        r.interval_us         = iv;
        r.sample_count        = cnt;
        r.interval_min        = lo;
        r.interval_max        = hi;
        r.interval_mean       = mean;
        r.interval_square_sum = sq;
        r.jitter_us           = jit;
        r.jitter_mean         = jmean;
        r.jitter_lo           = jlo;
        r.jitter_hi           = jhi;
        return r;
    endfunction

    // advance the local statistics by one accepted word and give the result
    task automatic predict_stats(input t_word_action act, input logic [62:0] ts,
                                 output t_result r);
        logic [62:0] gap;
        logic [63:0] iv;
        logic [63:0] sq;
        logic [63:0] jit;
        logic [63:0] old_n;
        r = '0;
        if (en_mirror) begin
            if (act == ACT_RESTART || !base_ok) begin
                base_ts = ts;
                base_ok = 1'b1;
            end else begin
                // 63-bit difference, so a counter wrap comes out small
                gap   = ts - base_ts;
                iv    = ({1'b0, gap} > IV_CEIL) ? IV_CEIL : {1'b0, gap};
                sq    = (iv > 64'hFFFF_FFFF) ? '1 : iv * iv;
                old_n = n_samples;
                if (n_samples < COUNT_CEIL)
                    n_samples = n_samples + 64'd1;
                iv_total = sum_clamped(iv_total, iv);
                sq_total = sum_clamped(sq_total, sq);
                if (old_n == 0) begin
                    iv_lo = iv;
                    iv_hi = iv;
                end else begin
                    jit = (iv > iv_prev) ? iv - iv_prev : iv_prev - iv;
                    if (iv > iv_hi)
                        iv_hi = iv;
                    if (iv < iv_lo)
                        iv_lo = iv;
                    jit_last = jit;
                    if (old_n == 1) begin
                        jit_total = jit;
                        jit_lo    = jit;
                        jit_hi    = jit;
                    end else begin
                        jit_total = sum_clamped(jit_total, jit);
                        if (jit > jit_hi)
                            jit_hi = jit;
                        if (jit < jit_lo)
                            jit_lo = jit;
                    end
                end
                iv_prev    = iv;
                base_ts    = ts;
                r.measured = 1'b1;
            end
        end
        r.interval_us         = to_field(iv_prev);
        r.sample_count        = to_field(n_samples);
        r.interval_min        = to_field(iv_lo);
        r.interval_max        = to_field(iv_hi);
        r.interval_mean       = (n_samples != 0) ? to_field(iv_total / n_samples) : '0;
        r.interval_square_sum = sq_total;
        r.jitter_us           = to_field(jit_last);
        r.jitter_mean         = (n_samples >= 2) ?
                                to_field(jit_total / (n_samples - 64'd1)) : '0;
        r.jitter_lo           = to_field(jit_lo);
        r.jitter_hi           = to_field(jit_hi);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // outputs sampled at the edge, before the block updates them
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_stats.size() == 0) begin
                report_mismatch("result word with nothing expected",
                                64'(o_sample_count), 64'd0);
            end else begin
                want = pending_stats.pop_front();
                check_field("measured", 64'(o_measured), 64'(want.measured));
                check_field("interval_us", 64'(o_interval_us), 64'(want.interval_us));
                check_field("sample_count", 64'(o_sample_count), 64'(want.sample_count));
                check_field("interval_min", 64'(o_interval_min), 64'(want.interval_min));
                check_field("interval_max", 64'(o_interval_max), 64'(want.interval_max));
                check_field("interval_mean", 64'(o_interval_mean),
                            64'(want.interval_mean));
                check_field("interval_square_sum", o_interval_square_sum,
                            want.interval_square_sum);
                check_field("jitter_us", 64'(o_jitter_us), 64'(want.jitter_us));
                check_field("jitter_mean", 64'(o_jitter_mean), 64'(want.jitter_mean));
                check_field("jitter_lo", 64'(o_jitter_lo), 64'(want.jitter_lo));
                check_field("jitter_hi", 64'(o_jitter_hi), 64'(want.jitter_hi));
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, or one long hold-off when asked for
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stretch;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                stretch      = hold_request;
                hold_request = 0;
                i_stall <= 1'b1;
                repeat (stretch) @(posedge i_clk);
            end else begin
                i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one word, hold it until taken, then log what should come back
    task automatic send_word(input t_word_action act, input logic [62:0] ts,
                             input bit typed, input t_result typed_stats);
        t_result predicted;
        int      gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            // mostly short gaps, now and then one long enough to span a word
            gap = ($urandom_range(4) == 0) ? $urandom_range(5, 160) : $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_timestamp_us <= ts;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_stats(act, ts, predicted);
        pending_stats.push_back(typed ? typed_stats : predicted);
    endtask

    // stop offering and wait until every expected word is back
    task automatic wait_results_drained(input int extra);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_stats.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // the enable register is only touched once the block has gone quiet
    task automatic write_enable(input logic value);
        wait_results_drained(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        en_mirror = value;
        i_cfg_valid <= 1'b0;
    endtask

    // mostly steady timing streams, a few restarts and some pure noise
    task automatic next_random_word(output t_word_action act, output logic [62:0] ts);
        int unsigned pick;
        int unsigned size_pick;
        logic [62:0] step;
        pick      = $urandom_range(99);
        size_pick = $urandom_range(99);
        if (size_pick < 75)
            step = 63'($urandom_range(0, 3000));
        else if (size_pick < 90)
            step = 63'($urandom_range(0, 1 << 20));
        else if (size_pick < 95)
            step = 63'($urandom);
        else if (size_pick < 98)
            step = 63'hFFFF_FFFE + 63'($urandom_range(0, 2));   // around the clamp point
        else
            step = 63'({$urandom, $urandom});                    // far jump, may wrap
        if (pick < 85) begin
            act = ACT_MEASURE;
            ts  = ts_cursor + step;
        end else if (pick < 93) begin
            act = ACT_RESTART;
            ts  = ts_cursor + step;
        end else begin
            act = t_word_action'($urandom_range(1));
            ts  = 63'({$urandom, $urandom});
        end
        ts_cursor = ts;
    endtask

    task automatic run_phase(input logic en, input int idle, input int stall,
                             input int items, input bit with_hold, input bit with_pause);
        t_word_action act;
        logic [62:0]  ts;
        int           k;
        write_enable(en);
        idle_pct  = idle;
        stall_pct = stall;
        for (k = 0; k < items; k++) begin
            // long hold-off while words keep coming, so the queue fills
            if (with_hold && k == 20)
                hold_request = HOLD_CYCLES;
            if (with_pause && k == items / 2)
                wait_results_drained(0);
            next_random_word(act, ts);
            send_word(act, ts, 1'b0, '0);
        end
    endtask

    // directed table entries
    task automatic add_word(input t_word_action act, input logic [62:0] ts);
        t_stim_row row;
        row = '{ROW_WORD, act, ts, ENABLE_ON, 1'b0, '0};
        stim_rows.push_back(row);
    endtask

    task automatic add_checked(input t_word_action act, input logic [62:0] ts,
                               input t_result stats);
        t_stim_row row;
        row = '{ROW_WORD, act, ts, ENABLE_ON, 1'b1, stats};
        stim_rows.push_back(row);
    endtask

    task automatic add_config(input logic value);
        t_stim_row row;
        row = '{ROW_CONFIG, ACT_RESTART, '0, value, 1'b0, '0};
        stim_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= ENABLE_ON;
        i_valid        <= 1'b0;
        i_action       <= ACT_RESTART;
        i_timestamp_us <= '0;

        // measure with no baseline only sets it
        add_checked(ACT_MEASURE, 63'd1000,
                    stats_word(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0,
                               32'd0, 32'd0, 32'd0, 32'd0));
        add_checked(ACT_MEASURE, 63'd1100,
                    stats_word(1'b1, 32'd100, 32'd1, 32'd100, 32'd100, 32'd100, 64'd10000,
                               32'd0, 32'd0, 32'd0, 32'd0));
        // zero interval, first jitter sample
        add_checked(ACT_MEASURE, 63'd1100,
                    stats_word(1'b1, 32'd0, 32'd2, 32'd0, 32'd100, 32'd50, 64'd10000,
                               32'd100, 32'd100, 32'd100, 32'd100));
        // restart moves the baseline and leaves the statistics alone
        add_checked(ACT_RESTART, 63'd5000,
                    stats_word(1'b0, 32'd0, 32'd2, 32'd0, 32'd100, 32'd50, 64'd10000,
                               32'd100, 32'd100, 32'd100, 32'd100));
        add_word(ACT_MEASURE, 63'd5300);
        add_word(ACT_MEASURE, 63'd5340);
        // all-ones timestamp, interval far beyond the clamp
        add_word(ACT_MEASURE, 63'h7FFF_FFFF_FFFF_FFFF);
        // counter wrap past all ones gives a short interval
        add_word(ACT_MEASURE, 63'd9);
        // timestamp below the baseline, clamps and pushes the square sum over
        add_word(ACT_MEASURE, 63'd3);
        add_word(ACT_RESTART, 63'd0);
        // exactly the largest interval, then one just past it
        add_word(ACT_MEASURE, 63'hFFFF_FFFF);
        add_word(ACT_MEASURE, 63'h1_FFFF_FFFF);
        add_word(ACT_MEASURE, 63'h2_0000_0006);
        add_word(ACT_MEASURE, 63'h2_0000_0007);
        // disabled: words come back with measured low and nothing moves
        add_config(ENABLE_OFF);
        add_word(ACT_MEASURE, 63'h5555_5555_5555_5555);
        add_word(ACT_RESTART, 63'd0);
        add_word(ACT_MEASURE, 63'h2AAA_AAAA_AAAA_AAAA);
        add_config(ENABLE_ON);
        add_word(ACT_MEASURE, 63'h2_0000_0020);
        add_word(ACT_RESTART, 63'h2AAA_AAAA_AAAA_AAAA);
        add_word(ACT_MEASURE, 63'h2AAA_AAAA_AAAA_AF7C);
        add_word(ACT_MEASURE, 63'h5555_5555_5555_5555);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CONFIG)
                write_enable(stim_rows[i].cfg_value);
            else
                send_word(stim_rows[i].act, stim_rows[i].ts, stim_rows[i].typed,
                          stim_rows[i].stats);
        end
        ts_cursor = 63'h5555_5555_5555_5555;

        //        enable      idle stall items hold pause
        run_phase(ENABLE_ON,  0,   0,    160,  1'b1, 1'b0);
        run_phase(ENABLE_ON,  59,  0,    160,  1'b0, 1'b1);
        run_phase(ENABLE_ON,  0,   59,   160,  1'b0, 1'b0);
        run_phase(ENABLE_ON,  34,  34,   160,  1'b0, 1'b0);
        run_phase(ENABLE_OFF, 34,  34,   40,   1'b0, 1'b0);
        run_phase(ENABLE_ON,  0,   0,    60,   1'b0, 1'b0);

        wait_results_drained(SETTLE_CYCLES);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ijs_pkg.sv
rtl/ijs_front.sv
rtl/ijs_fifo.sv
rtl/ijs_div.sv
rtl/ijs_back.sv
rtl/interval_jitter_statistics.sv
rtl/ijs_checker.sv
verif/interval_jitter_statistics_tb.sv
